>>> hw/rtl/extended_gcd_signed_top_assert.svh
// assertion macros for the extended gcd block
`ifndef EXTENDED_GCD_SIGNED_TOP_ASSERT_SVH
`define EXTENDED_GCD_SIGNED_TOP_ASSERT_SVH

// same-cycle implication
`define EGCD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define EGCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/egcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_pkg
// shared types for the extended gcd controller and datapath
// ----------------------------------------------------------------------------
package egcd_pkg;

	localparam int unsigned IO_WIDTH  = 64;
	localparam int unsigned GCD_WIDTH = 63;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_GROW,
		S_SUB,
		S_UPDATE,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic grow;
		logic sub;
		logic update;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic mb_zero;
		logic can_grow;
		logic k_zero;
	} status_t;

endpackage

>>> hw/rtl/egcd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_datapath
// euclid remainders, bezout coefficients and shift-subtract quotient unit
// ----------------------------------------------------------------------------
module egcd_datapath #(
	parameter int unsigned W = 64
) (
	input  logic                              clk,
	input  logic [egcd_pkg::IO_WIDTH-1:0]     operand_a,
	input  logic [egcd_pkg::IO_WIDTH-1:0]     operand_b,
	input  egcd_pkg::cmd_t                    cmd,
	output egcd_pkg::status_t                 status,
	output logic [egcd_pkg::GCD_WIDTH-1:0]    gcd_value,
	output logic [egcd_pkg::IO_WIDTH-1:0]     coef_x,
	output logic [egcd_pkg::IO_WIDTH-1:0]     coef_y
);
	import egcd_pkg::*;

	localparam int unsigned KW = (W > 1) ? $clog2(W) : 1;

	logic [W-1:0]  ma_q, mb_q, xc_q, yc_q, xn_q, yn_q;
	logic [W-1:0]  rem_q, xt_q, yt_q;
	logic [KW-1:0] k_q;
	logic          neg_a_q, neg_b_q;
	logic [GCD_WIDTH-1:0] gcd_q;
	logic [IO_WIDTH-1:0]  x_q, y_q;

	logic [W-1:0]  a_w, b_w, d, xs, ys, xf, yf;
	logic [W:0]    d_next;
	logic [KW:0]   k_inc;
	logic [IO_WIDTH-1:0] ma_ext;

	always_comb begin
		a_w    = operand_a[W-1:0];
		b_w    = operand_b[W-1:0];
		d      = mb_q << k_q;
		xs     = xn_q << k_q;
		ys     = yn_q << k_q;
		k_inc  = {1'b0, k_q} + 1'b1;
		d_next = {1'b0, mb_q} << k_inc;
		status.mb_zero  = (mb_q == '0);
		status.can_grow = (k_inc < (KW+1)'(W)) && (d_next <= {1'b0, rem_q});
		status.k_zero   = (k_q == '0);
		xf     = neg_a_q ? (W'(0) - xc_q) : xc_q;
		yf     = neg_b_q ? (W'(0) - yc_q) : yc_q;
		ma_ext = IO_WIDTH'(ma_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_a_q <= a_w[W-1];
			neg_b_q <= b_w[W-1];
			ma_q    <= a_w[W-1] ? (W'(0) - a_w) : a_w;
			mb_q    <= b_w[W-1] ? (W'(0) - b_w) : b_w;
			xc_q    <= W'(1);
			yc_q    <= '0;
			xn_q    <= '0;
			yn_q    <= W'(1);
		end
		if (cmd.div_start) begin
			rem_q <= ma_q;
			xt_q  <= xc_q;
			yt_q  <= yc_q;
			k_q   <= '0;
		end
		if (cmd.grow) begin
			k_q <= k_inc[KW-1:0];
		end
		if (cmd.sub) begin
			if (rem_q >= d) begin
				rem_q <= rem_q - d;
				xt_q  <= xt_q - xs;
				yt_q  <= yt_q - ys;
			end
			if (k_q != '0) begin
				k_q <= k_q - 1'b1;
			end
		end
		if (cmd.update) begin
			ma_q <= mb_q;
			mb_q <= rem_q;
			xc_q <= xn_q;
			xn_q <= xt_q;
			yc_q <= yn_q;
			yn_q <= yt_q;
		end
		if (cmd.finish) begin
			gcd_q <= ma_ext[GCD_WIDTH-1:0];
			x_q   <= IO_WIDTH'($signed(xf));
			y_q   <= IO_WIDTH'($signed(yf));
		end
	end

	assign gcd_value = gcd_q;
	assign coef_x    = x_q;
	assign coef_y    = y_q;

endmodule

>>> hw/rtl/egcd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_ctrl
// sequencer for euclid steps and output transaction handshake
// ----------------------------------------------------------------------------
module egcd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  egcd_pkg::status_t status,
	output egcd_pkg::cmd_t    cmd
);
	import egcd_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (status.mb_zero) begin
					state_d = S_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_GROW;
				end
			end
			S_GROW: begin
				if (status.can_grow) begin
					cmd.grow = 1'b1;
				end else begin
					state_d = S_SUB;
				end
			end
			S_SUB: begin
				cmd.sub = 1'b1;
				if (status.k_zero) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_CHECK;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> hw/rtl/extended_gcd_signed_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_gcd_signed_top
// signed extended euclid: gcd of magnitudes and bezout coefficients
// ----------------------------------------------------------------------------
// One transaction at a time. Each Euclid step runs a zero check, then a
// shift-subtract quotient that first aligns the divisor by left shifts and
// then subtracts back down bit by bit, then an update of remainders and
// coefficients. Loading the operands, the final zero check and writing the
// result come on top. The quotient bit lengths summed over all steps are
// bounded by about DATA_WIDTH. A finished result waits in the output
// register while the next transaction is accepted.
module extended_gcd_signed_top #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [egcd_pkg::IO_WIDTH-1:0]  operand_a,
	input  logic [egcd_pkg::IO_WIDTH-1:0]  operand_b,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [egcd_pkg::GCD_WIDTH-1:0] gcd_value,
	output logic [egcd_pkg::IO_WIDTH-1:0]  coef_x,
	output logic [egcd_pkg::IO_WIDTH-1:0]  coef_y
);
	import egcd_pkg::*;

	cmd_t    cmd;
	status_t status;

	egcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	egcd_datapath #(.W(DATA_WIDTH)) u_dp (
		.clk       (clk),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.cmd       (cmd),
		.status    (status),
		.gcd_value (gcd_value),
		.coef_x    (coef_x),
		.coef_y    (coef_y)
	);

endmodule

>>> hw/rtl/egcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_checker
// port-level checks on the extended gcd block, bound to the top level
// ----------------------------------------------------------------------------
`include "extended_gcd_signed_top_assert.svh"

module egcd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [egcd_pkg::GCD_WIDTH-1:0] gcd_value,
	input logic [egcd_pkg::IO_WIDTH-1:0]  coef_x,
	input logic [egcd_pkg::IO_WIDTH-1:0]  coef_y
);
	`EGCD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`EGCD_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready,
		$stable(gcd_value) && $stable(coef_x) && $stable(coef_y))
	`EGCD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
endmodule

bind extended_gcd_signed_top egcd_checker u_egcd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.gcd_value (gcd_value),
	.coef_x    (coef_x),
	.coef_y    (coef_y)
);

>>> tb/extended_gcd_signed_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_gcd_signed_top_tb
// checks gcd and bezout coefficients of the signed extended euclid block
// ----------------------------------------------------------------------------
// A table of directed operand pairs runs first, some rows with typed-in
// results. Random pairs follow: magnitudes of varied size, some with shared
// factors, plus small values and sign mixes. Transactions without typed-in
// results are checked against an in-bench euclid calculation. Both handshake
// sides stall in random bursts, and the receiver holds off once for a long
// stretch. The final part of the run has no stalls.
module extended_gcd_signed_top_tb;

	import egcd_pkg::*;

	localparam int unsigned DW = 64;
	localparam int N_RANDOM = 1130;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic [GCD_WIDTH-1:0] g;
		logic [IO_WIDTH-1:0]  x;
		logic [IO_WIDTH-1:0]  y;
	} egcd_res_t;

	typedef struct {
		logic [IO_WIDTH-1:0] a;
		logic [IO_WIDTH-1:0] b;
		bit                  typed;
		egcd_res_t           res;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [IO_WIDTH-1:0]  operand_a;
	logic [IO_WIDTH-1:0]  operand_b;
	logic                 out_valid;
	logic                 out_ready;
	logic [GCD_WIDTH-1:0] gcd_value;
	logic [IO_WIDTH-1:0]  coef_x;
	logic [IO_WIDTH-1:0]  coef_y;

	egcd_res_t  pending_results[$];
	int         errors;
	int         idle_cycles;
	int         row_idx;
	bit         calm;
	bit         hold_off;

	extended_gcd_signed_top #(.DATA_WIDTH(DW)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.gcd_value(gcd_value),
		.coef_x(coef_x),
		.coef_y(coef_y)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic egcd_res_t bezout(logic [IO_WIDTH-1:0] a, logic [IO_WIDTH-1:0] b);
		logic [DW-1:0] ma, mb, q, r, xc, yc, xn, yn, xt, yt;
		egcd_res_t res;
		ma = a[DW-1] ? -a[DW-1:0] : a[DW-1:0];
		mb = b[DW-1] ? -b[DW-1:0] : b[DW-1:0];
		xc = DW'(1);
		yc = '0;
		xn = '0;
		yn = DW'(1);
		while (mb != 0) begin
			q = ma / mb;
			r = ma % mb;
			xt = xc - q * xn;
			yt = yc - q * yn;
			ma = mb;
			mb = r;
			xc = xn;
			xn = xt;
			yc = yn;
			yn = yt;
		end
		if (a[DW-1])
			xc = -xc;
		if (b[DW-1])
			yc = -yc;
		res.g = ma[GCD_WIDTH-1:0];
		res.x = IO_WIDTH'($signed(xc));
		res.y = IO_WIDTH'($signed(yc));
		return res;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// random operand pair of varied size, partly with common factors
	task automatic make_pair(output logic [63:0] a, output logic [63:0] b);
		logic [63:0] f;
		int sel;
		sel = $urandom_range(0, 9);
		a = rand64() >> $urandom_range(1, 63);
		b = rand64() >> $urandom_range(1, 63);
		if (sel < 3) begin
			f = rand64() >> $urandom_range(33, 62);
			a = (a >> 32) * (f == 0 ? 1 : f);
			b = (b >> 32) * (f == 0 ? 1 : f);
		end else if (sel == 3) begin
			a = $urandom_range(0, 20);
			b = $urandom_range(0, 20);
		end else if (sel == 4) begin
			a = rand64();
			b = rand64();
		end
		a[63] = 1'b0;
		b[63] = 1'b0;
		if ($urandom_range(0, 1))
			a = -a;
		if ($urandom_range(0, 1))
			b = -b;
		if ($urandom_range(0, 99) == 0)
			a = 64'h8000_0000_0000_0000;
	endtask

	task automatic send(logic [63:0] a, logic [63:0] b);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid <= 1'b1;
		operand_a <= a;
		operand_b <= b;
		while (!in_ready)
			@(negedge clk);
		@(negedge clk);
	endtask

	stim_row_t rows[$];

	task automatic add_row(logic [63:0] a, logic [63:0] b, bit typed,
			logic [62:0] g, logic [63:0] x, logic [63:0] y);
		stim_row_t row;
		row.a = a;
		row.b = b;
		row.typed = typed;
		row.res = '{g: g, x: x, y: y};
		rows.push_back(row);
	endtask

	// record expectation at acceptance
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			if (row_idx < rows.size()) begin
				pending_results.push_back(rows[row_idx].typed ? rows[row_idx].res
					: bezout(operand_a, operand_b));
				row_idx++;
			end else
				pending_results.push_back(bezout(operand_a, operand_b));
		end
	end

	always @(posedge clk) begin
		egcd_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected transaction g=%0h", gcd_value);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (gcd_value !== e.g) begin
					$error("gcd_value expected %0h actual %0h", e.g, gcd_value);
					errors++;
				end
				if (coef_x !== e.x) begin
					$error("coef_x expected %0h actual %0h", e.x, coef_x);
					errors++;
				end
				if (coef_y !== e.y) begin
					$error("coef_y expected %0h actual %0h", e.y, coef_y);
					errors++;
				end
			end
		end
	end

	// receiver stalls
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off)
				out_ready <= 1'b0;
			else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				out_ready <= 1'b1;
			end else
				out_ready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [63:0] a, b;
		int n;
		errors = 0;
		row_idx = 0;
		calm = 0;
		hold_off = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operand_a = '0;
		operand_b = '0;

		// zero cases and extremes, then sign mixes and known pairs
		add_row(64'd0, 64'd0, 1, 63'd0, 64'd1, 64'd0);
		add_row(64'd5, 64'd0, 1, 63'd5, 64'd1, 64'd0);
		add_row(-64'sd5, 64'd0, 1, 63'd5, -64'sd1, 64'd0);
		add_row(64'd0, 64'd7, 1, 63'd7, 64'd0, 64'd1);
		add_row(64'd0, -64'sd7, 1, 63'd7, 64'd0, -64'sd1);
		add_row(64'h7fff_ffff_ffff_ffff, 64'd0, 1, 63'h7fff_ffff_ffff_ffff, 64'd1, 64'd0);
		add_row(64'h8000_0000_0000_0001, 64'd0, 1, 63'h7fff_ffff_ffff_ffff, -64'sd1, 64'd0);
		add_row(64'h8000_0000_0000_0000, 64'd0, 1, 63'd0, -64'sd1, 64'd0);
		add_row(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 0, 0, 0, 0);
		add_row(64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0001, 0, 0, 0, 0);
		add_row(64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_fffe, 0, 0, 0, 0);
		add_row(64'h8000_0000_0000_0001, 64'd1, 0, 0, 0, 0);
		add_row(64'd1, 64'h7fff_ffff_ffff_ffff, 0, 0, 0, 0);
		add_row(64'd240, 64'd46, 0, 0, 0, 0);
		add_row(-64'sd240, 64'd46, 0, 0, 0, 0);
		add_row(64'd240, -64'sd46, 0, 0, 0, 0);
		add_row(-64'sd240, -64'sd46, 0, 0, 0, 0);
		add_row(64'd7540113804746346429, 64'd4660046610375530309, 0, 0, 0, 0);
		add_row(64'd12, 64'd12, 0, 0, 0, 0);
		add_row(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 0, 0, 0, 0);
		add_row(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaab, 0, 0, 0, 0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		n = rows.size();
		for (int i = 0; i < n; i++)
			send(rows[i].a, rows[i].b);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 200) begin
				// long receiver hold-off while items keep coming
				hold_off = 1;
				fork
					begin
						repeat (400) @(negedge clk);
						hold_off = 0;
					end
				join_none
			end
			if (i == N_RANDOM - 150)
				calm = 1;
			make_pair(a, b);
			send(a, b);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
